>>> hw/rtl/tuar_pkg.sv
package tuar_pkg;

    localparam int TEX_ENTRIES_DEF = 256;
    localparam int INDEX_SPACE     = 256;
    localparam int Q_DEPTH         = 4;

    localparam int IN_DATA_W  = 144;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 96;
    localparam int OUT_USER_W = 1;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_TRI   = 2'd1;
    localparam logic [1:0] KIND_QUAD  = 2'd2;

    // Eight coordinates, element 0 is u_a, then v_a, u_b, v_b, u_c, v_c, u_d, v_d.
    typedef logic [7:0][7:0] coord_vec_t;

    typedef struct packed {
        logic        hit;
        logic        quad;
        logic [63:0] word;
        logic [7:0]  idx;
        coord_vec_t  coords;
    } tuar_item_t;

    typedef struct packed {
        logic push;
        logic full;
    } tuar_qctl_t;

endpackage

>>> hw/rtl/tuar_front.sv
module tuar_front
    import tuar_pkg::*;
#(
    parameter int TEX_ENTRIES = TEX_ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  in_kind,
    input  logic [7:0]  in_index,
    input  logic        in_entry_valid,
    input  logic [63:0] in_word,
    input  coord_vec_t  in_coords,
    output tuar_qctl_t  qctl_out,
    input  logic        q_full,
    output tuar_item_t  push_item
);

    localparam int DEPTH = (TEX_ENTRIES < INDEX_SPACE) ? TEX_ENTRIES : INDEX_SPACE;
    localparam int IW    = $clog2(DEPTH);

    logic [63:0]   mem_reg [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [63:0]   rd_word_reg;

    logic          s1_valid_reg, s1_valid_next;
    logic          s1_hit_reg;
    logic          s1_quad_reg;
    logic [7:0]    s1_idx_reg;
    coord_vec_t    s1_coords_reg;

    logic          accept;
    logic          in_range;
    logic [IW-1:0] addr;
    logic          wr_en;
    logic          lookup;
    logic          push;

    assign addr     = in_index[IW-1:0];
    assign in_range = (32'(in_index) < 32'(DEPTH));
    assign push     = s1_valid_reg && !q_full;
    assign in_ready = !s1_valid_reg || !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        wr_en  = 1'b0;
        lookup = 1'b0;
        unique case (in_kind)
            KIND_WRITE: wr_en  = accept && in_range;
            KIND_TRI:   lookup = accept;
            KIND_QUAD:  lookup = accept;
            default:    ;
        endcase
    end

    assign s1_valid_next = lookup ? 1'b1 : (push ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[addr] <= in_word;
        end
        if (lookup)
        begin
            rd_word_reg   <= mem_reg[addr];
            s1_hit_reg    <= in_range && valid_reg[addr];
            s1_quad_reg   <= (in_kind == KIND_QUAD);
            s1_idx_reg    <= in_index;
            s1_coords_reg <= in_coords;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[addr] <= in_entry_valid;
            end
            s1_valid_reg <= s1_valid_next;
        end
    end

    assign qctl_out.push  = push;
    assign qctl_out.full  = q_full;
    assign push_item.hit    = s1_hit_reg;
    assign push_item.quad   = s1_quad_reg;
    assign push_item.word   = rd_word_reg;
    assign push_item.idx    = s1_idx_reg;
    assign push_item.coords = s1_coords_reg;

endmodule

>>> hw/rtl/tuar_queue.sv
module tuar_queue
    import tuar_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  tuar_qctl_t qctl_in,
    input  tuar_item_t push_item,
    output logic       full,
    input  logic       pop,
    output logic       not_empty,
    output tuar_item_t pop_item
);

    localparam int PW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    tuar_item_t    slot_reg [Q_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full      = (count_reg == CW'(Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = qctl_in.push && !qctl_in.full;
    assign do_pop    = pop && not_empty;
    assign pop_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? PW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? PW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hw/rtl/tuar_back.sv
module tuar_back
    import tuar_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  tuar_item_t            q_item,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data,
    output logic [OUT_USER_W-1:0] out_user
);

    // Stage one: scaled sizes from the eight multipliers.
    logic             b1_valid_reg;
    logic             b1_hit_reg;
    logic [7:0]       b1_map_reg;
    logic [15:0]      b1_pal_reg;
    logic [15:0]      b1_page_reg;
    logic [7:0]       b1_x_reg;
    logic [7:0]       b1_y_reg;
    coord_vec_t       b1_coords_reg;
    logic [7:0][8:0]  b1_scaled_reg;
    logic [7:0][8:0]  scaled_next;
    logic [7:0]       map_next;

    // Stage two: output register.
    logic                  o_valid_reg;
    logic [OUT_DATA_W-1:0] o_data_reg;
    logic                  o_user_reg;
    coord_vec_t            coords_out;

    logic o_ready;
    logic b1_ready;

    assign o_ready  = !o_valid_reg || out_ready;
    assign b1_ready = !b1_valid_reg || o_ready;
    assign pop      = q_valid && b1_ready;

    always_comb
    begin
        logic [15:0] prod;
        logic [7:0]  size;
        for (int i = 0; i < 8; i++)
        begin
            size           = (i % 2 == 0) ? q_item.word[15:8] : q_item.word[7:0];
            prod           = 16'(size) * 16'(q_item.coords[i]);
            scaled_next[i] = prod[15:7];
            map_next[i]    = q_item.hit && (q_item.quad || (i < 6));
        end
    end

    always_comb
    begin
        logic [9:0] sum;
        logic [7:0] off;
        for (int i = 0; i < 8; i++)
        begin
            off = (i % 2 == 0) ? b1_x_reg : b1_y_reg;
            sum = 10'(off) + 10'(b1_scaled_reg[i]);
            if (!b1_map_reg[i])
            begin
                coords_out[i] = b1_coords_reg[i];
            end
            else if (sum == 10'd256)
            begin
                coords_out[i] = 8'd255;
            end
            else if (sum > 10'd256)
            begin
                coords_out[i] = 8'd8;
            end
            else
            begin
                coords_out[i] = sum[7:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b1_hit_reg    <= q_item.hit;
            b1_map_reg    <= map_next;
            b1_pal_reg    <= q_item.hit ? q_item.word[63:48] : 16'd0;
            b1_page_reg   <= q_item.hit ? q_item.word[47:32] : {8'd0, q_item.idx};
            b1_x_reg      <= q_item.word[31:24];
            b1_y_reg      <= q_item.word[23:16];
            b1_coords_reg <= q_item.coords;
            b1_scaled_reg <= scaled_next;
        end
        if (b1_valid_reg && o_ready)
        begin
            o_data_reg <= {coords_out, b1_page_reg, b1_pal_reg};
            o_user_reg <= b1_hit_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            if (b1_ready)
            begin
                b1_valid_reg <= q_valid;
            end
            if (o_ready)
            begin
                o_valid_reg <= b1_valid_reg;
            end
        end
    end

    assign out_valid = o_valid_reg;
    assign out_data  = o_data_reg;
    assign out_user  = o_user_reg;

endmodule

>>> hw/rtl/texture_uv_atlas_remap_top.sv
// Channel  Dir  Signals                        Contents
// s_       in   s_tvalid s_tready s_tdata/user  table writes and polygons
// m_       out  m_tvalid m_tready m_tdata/user  remapped polygons
//
// One beat is taken per cycle while the queue has room. A polygon passes the
// table read register, one queue slot, the multiplier register and the output
// register before it is offered on the master side.
// Reset clears the valid bit of every table entry and all control state; the
// table words themselves are not cleared and are only seen after a write.
// A four-entry queue between the lookup front end and the arithmetic back end
// lets either side stall alone; table writes and ignored beats give no output.
module texture_uv_atlas_remap_top
    import tuar_pkg::*;
#(
    parameter int TEX_ENTRIES = TEX_ENTRIES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // tex_index[7:0], entry_valid[8], entry_word[72:9], u_a, v_a, u_b, v_b,
    // u_c, v_c, u_d, v_d at 8 bits each from bit 73, zero pad [143:137]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // kind[1:0]
    input  logic [IN_USER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // palette_out[15:0], page_out[31:16], u_a_out, v_a_out, u_b_out, v_b_out,
    // u_c_out, v_c_out, u_d_out, v_d_out at 8 bits each from bit 32
    output logic [OUT_DATA_W-1:0] m_tdata,
    // remapped[0]
    output logic [OUT_USER_W-1:0] m_tuser
);

    tuar_qctl_t qctl;
    tuar_item_t push_item;
    tuar_item_t pop_item;
    logic       q_full;
    logic       q_not_empty;
    logic       q_pop;
    coord_vec_t in_coords;

    assign in_coords = s_tdata[136:73];

    tuar_front #(
        .TEX_ENTRIES (TEX_ENTRIES)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_kind        (s_tuser),
        .in_index       (s_tdata[7:0]),
        .in_entry_valid (s_tdata[8]),
        .in_word        (s_tdata[72:9]),
        .in_coords      (in_coords),
        .qctl_out       (qctl),
        .q_full         (q_full),
        .push_item      (push_item)
    );

    tuar_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .qctl_in   (qctl),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (pop_item)
    );

    tuar_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .q_item    (pop_item),
        .pop       (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_user  (m_tuser)
    );

endmodule

>>> hw/rtl/tuar_checker.sv
module tuar_checker
    import tuar_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [OUT_USER_W-1:0] m_tuser
);

    // A stalled output beat keeps its data.
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output data changed during a stall");

    // A beat that was not remapped carries a zero palette.
    a_miss_palette: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[15:0] == 16'd0)
        else $error("palette set on a pass-through beat");

    // A pass-through page word holds only the eight-bit table index.
    a_miss_page: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[31:24] == 8'd0)
        else $error("pass-through page wider than the index");

    // Nothing is offered straight after reset.
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("output valid just after reset");

endmodule

bind texture_uv_atlas_remap_top tuar_checker u_chk (.*);
